FILE: rtl/sih_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sih_pkg: shared constants for the string intern hash table
// Sizes, the FNV-1a offset basis and status codes used by sih_fnv and the table.
// ----------------------------------------------------------------------------
package sih_pkg;

    localparam int SLOTS       = 4096;
    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int STORE_BYTES = 65536;
    localparam int STORE_AW    = $clog2(STORE_BYTES);
    localparam int USED_W      = STORE_AW + 1;
    localparam int MAX_LEN     = 256;
    localparam int STG_AW      = $clog2(MAX_LEN);
    localparam int LEN_W       = $clog2(MAX_LEN + 2);

    localparam int HANDLE_W  = 12;
    localparam int OFFSET_W  = 16;
    localparam int ENTRIES_W = 13;
    localparam int SAVED_W   = 32;
    localparam int STATUS_W  = 3;
    localparam int HASH_W    = 64;

    // Slot word: valid, hash, length, offset
    localparam int SLOT_DW = 1 + HASH_W + LEN_W + STORE_AW;

    localparam logic [HASH_W-1:0] FNV_BASIS = 64'd14695981039346656037;

    localparam logic [STATUS_W-1:0] ST_FOUND      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd3;
    localparam logic [STATUS_W-1:0] ST_STORE_FULL = 3'd4;

endpackage

FILE: rtl/sih_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sih_ram: simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sih_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/sih_fnv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sih_fnv: one FNV-1a byte step
// Xor the byte in and multiply by the 64-bit prime 2^40 + 435 as shift-adds.
// ----------------------------------------------------------------------------
module sih_fnv (
    input  logic [sih_pkg::HASH_W-1:0] hash_in,
    input  logic [7:0]                 byte_in,
    output logic [sih_pkg::HASH_W-1:0] hash_out
);

    logic [sih_pkg::HASH_W-1:0] x;

    assign x = hash_in ^ {56'd0, byte_in};

    // 435 = 256 + 128 + 32 + 16 + 2 + 1
    assign hash_out = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4)
                    + (x << 1) + x;

endmodule

FILE: rtl/string_intern_hash_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_intern_hash_table: FNV-1a string intern table with linear probing
// Hashes and stages string bytes, then probes a slot RAM, compares bytes
// against a byte store RAM and inserts new strings.
//
//   channel | dir | handshake         | payload
//   s_      | in  | s_valid / s_ready | mode, byte_value, carries_byte, last_byte
//   m_      | out | m_valid / m_ready | status, handle, offset, hash, counts
//
// A byte request is taken in S_IDLE. A string end passes S_END, then per
// probe S_PROBE_RD/S_PROBE_CK and per compared byte S_CMP_RD/S_CMP_CK; an
// insert adds S_CP_RD/S_CP_WR per copied byte and a last S_CP_RD to commit
// the slot, all through the registered-read byte store and slot RAM. After
// reset or a clear request, all SLOTS (4096) slots are cleared with s_ready
// low. A pending result stalls only the next string end, not byte requests.
// ----------------------------------------------------------------------------
module string_intern_hash_table (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [7:0]  s_byte_value,
    input  logic        s_carries_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [11:0] m_slot_handle,
    output logic [15:0] m_store_offset,
    output logic [63:0] m_string_hash,
    output logic [12:0] m_entries_held,
    output logic [31:0] m_bytes_saved
);

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_END      = 4'd2;
    localparam logic [3:0] S_PROBE_RD = 4'd3;
    localparam logic [3:0] S_PROBE_CK = 4'd4;
    localparam logic [3:0] S_CMP_RD   = 4'd5;
    localparam logic [3:0] S_CMP_CK   = 4'd6;
    localparam logic [3:0] S_CP_RD    = 4'd7;
    localparam logic [3:0] S_CP_WR    = 4'd8;
    localparam logic [3:0] S_DONE     = 4'd9;

    localparam int SW = sih_pkg::SLOT_W;
    localparam int LW = sih_pkg::LEN_W;
    localparam int UW = sih_pkg::USED_W;
    localparam int AW = sih_pkg::STORE_AW;
    localparam int HW = sih_pkg::HASH_W;

    logic [3:0]    state_reg, state_next;
    logic [SW:0]   clr_reg, clr_next;
    logic [HW-1:0] hash_reg, hash_next, hash_step;
    logic [LW-1:0] len_reg, len_next;
    logic [UW-1:0] used_reg, used_next;
    logic [12:0]   entries_reg, entries_next;
    logic [31:0]   saved_reg, saved_next;
    logic [SW-1:0] idx_reg, idx_next;
    logic [SW:0]   probes_reg, probes_next;
    logic [LW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] off_reg, off_next;
    logic [2:0]    res_status_reg, res_status_next;
    logic [SW-1:0] res_handle_reg, res_handle_next;
    logic [AW-1:0] res_off_reg, res_off_next;

    logic          m_valid_reg, m_valid_next;
    logic [2:0]    m_status_reg, m_status_next;
    logic [11:0]   m_handle_reg, m_handle_next;
    logic [15:0]   m_off_reg, m_off_next;
    logic [63:0]   m_hash_reg, m_hash_next;
    logic [12:0]   m_entries_reg, m_entries_next;
    logic [31:0]   m_saved_reg, m_saved_next;

    // slot RAM ports
    logic                       slot_we;
    logic [SW-1:0]              slot_waddr, slot_raddr;
    logic [sih_pkg::SLOT_DW-1:0] slot_wdata, slot_rdata;
    // byte store ports
    logic          store_we;
    logic [AW-1:0] store_waddr, store_raddr;
    logic [7:0]    store_wdata, store_rdata;
    // staging ports
    logic                       stg_we;
    logic [sih_pkg::STG_AW-1:0] stg_waddr, stg_raddr;
    logic [7:0]                 stg_rdata;

    logic          rd_valid;
    logic [HW-1:0] rd_hash;
    logic [LW-1:0] rd_len;
    logic [AW-1:0] rd_off;
    logic [UW+1:0] fit_sum;
    logic [32:0]   saved_sum;
    logic [AW:0]   cmp_addr;
    logic          accept;

    sih_fnv u_fnv (
        .hash_in  (hash_reg),
        .byte_in  (s_byte_value),
        .hash_out (hash_step)
    );

    sih_ram #(.WIDTH(sih_pkg::SLOT_DW), .DEPTH(sih_pkg::SLOTS)) u_slot_ram (
        .aclk  (aclk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    sih_ram #(.WIDTH(8), .DEPTH(sih_pkg::STORE_BYTES)) u_store_ram (
        .aclk  (aclk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (store_wdata),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    sih_ram #(.WIDTH(8), .DEPTH(sih_pkg::MAX_LEN)) u_stg_ram (
        .aclk  (aclk),
        .we    (stg_we),
        .waddr (stg_waddr),
        .wdata (s_byte_value),
        .raddr (stg_raddr),
        .rdata (stg_rdata)
    );

    assign {rd_valid, rd_hash, rd_len, rd_off} = slot_rdata;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign fit_sum  = (UW+2)'(used_reg) + (UW+2)'(len_reg) + (UW+2)'(1);
    assign saved_sum = {1'b0, saved_reg} + 33'(len_reg) + 33'd1;
    assign cmp_addr = (AW+1)'(off_reg) + (AW+1)'(cnt_reg);

    assign stg_we    = accept && !s_mode && s_carries_byte
                       && (len_reg < LW'(sih_pkg::MAX_LEN));
    assign stg_waddr = len_reg[sih_pkg::STG_AW-1:0];
    assign stg_raddr = cnt_reg[sih_pkg::STG_AW-1:0];

    always_comb begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        hash_next       = hash_reg;
        len_next        = len_reg;
        used_next       = used_reg;
        entries_next    = entries_reg;
        saved_next      = saved_reg;
        idx_next        = idx_reg;
        probes_next     = probes_reg;
        cnt_next        = cnt_reg;
        off_next        = off_reg;
        res_status_next = res_status_reg;
        res_handle_next = res_handle_reg;
        res_off_next    = res_off_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_handle_next   = m_handle_reg;
        m_off_next      = m_off_reg;
        m_hash_next     = m_hash_reg;
        m_entries_next  = m_entries_reg;
        m_saved_next    = m_saved_reg;

        slot_we     = 1'b0;
        slot_waddr  = idx_reg;
        slot_wdata  = {1'b1, hash_reg, len_reg, used_reg[AW-1:0]};
        slot_raddr  = idx_reg;
        store_we    = 1'b0;
        store_waddr = AW'(used_reg + UW'(cnt_reg));
        store_wdata = stg_rdata;
        store_raddr = cmp_addr[AW-1:0];

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR: begin
                slot_we    = 1'b1;
                slot_waddr = clr_reg[SW-1:0];
                slot_wdata = '0;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == (SW+1)'(sih_pkg::SLOTS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (s_mode) begin
                        // drop staged string and all contents
                        hash_next    = sih_pkg::FNV_BASIS;
                        len_next     = '0;
                        used_next    = '0;
                        entries_next = '0;
                        saved_next   = '0;
                        clr_next     = '0;
                        state_next   = S_CLEAR;
                    end else begin
                        if (s_carries_byte) begin
                            hash_next = hash_step;
                            if (len_reg <= LW'(sih_pkg::MAX_LEN)) begin
                                len_next = len_reg + 1'b1;
                            end
                        end
                        if (s_last_byte) begin
                            state_next = S_END;
                        end
                    end
                end
            end
            S_END: begin
                res_handle_next = '0;
                res_off_next    = '0;
                idx_next        = hash_reg[SW-1:0];
                probes_next     = '0;
                if (len_reg > LW'(sih_pkg::MAX_LEN)) begin
                    res_status_next = sih_pkg::ST_TOO_LONG;
                    state_next      = S_DONE;
                end else begin
                    state_next = S_PROBE_RD;
                end
            end
            S_PROBE_RD: begin
                state_next = S_PROBE_CK;
            end
            S_PROBE_CK: begin
                cnt_next = '0;
                off_next = rd_off;
                if (!rd_valid) begin
                    if (fit_sum > (UW+2)'(sih_pkg::STORE_BYTES)) begin
                        res_status_next = sih_pkg::ST_STORE_FULL;
                        state_next      = S_DONE;
                    end else begin
                        state_next = S_CP_RD;
                    end
                end else if (rd_hash == hash_reg && rd_len == len_reg) begin
                    if (len_reg == '0) begin
                        res_status_next = sih_pkg::ST_FOUND;
                        res_handle_next = idx_reg;
                        res_off_next    = rd_off;
                        saved_next      = saved_sum[32] ? '1 : saved_sum[31:0];
                        state_next      = S_DONE;
                    end else begin
                        state_next = S_CMP_RD;
                    end
                end else begin
                    idx_next    = idx_reg + 1'b1;
                    probes_next = probes_reg + 1'b1;
                    if (probes_reg == (SW+1)'(sih_pkg::SLOTS - 1)) begin
                        res_status_next = sih_pkg::ST_TABLE_FULL;
                        state_next      = S_DONE;
                    end else begin
                        state_next = S_PROBE_RD;
                    end
                end
            end
            S_CMP_RD: begin
                if (cmp_addr[AW]) begin
                    // past the end of the store: treat as mismatch
                    idx_next    = idx_reg + 1'b1;
                    probes_next = probes_reg + 1'b1;
                    if (probes_reg == (SW+1)'(sih_pkg::SLOTS - 1)) begin
                        res_status_next = sih_pkg::ST_TABLE_FULL;
                        state_next      = S_DONE;
                    end else begin
                        state_next = S_PROBE_RD;
                    end
                end else begin
                    state_next = S_CMP_CK;
                end
            end
            S_CMP_CK: begin
                if (stg_rdata != store_rdata) begin
                    idx_next    = idx_reg + 1'b1;
                    probes_next = probes_reg + 1'b1;
                    if (probes_reg == (SW+1)'(sih_pkg::SLOTS - 1)) begin
                        res_status_next = sih_pkg::ST_TABLE_FULL;
                        state_next      = S_DONE;
                    end else begin
                        state_next = S_PROBE_RD;
                    end
                end else if (cnt_reg + 1'b1 == len_reg) begin
                    res_status_next = sih_pkg::ST_FOUND;
                    res_handle_next = idx_reg;
                    res_off_next    = off_reg;
                    saved_next      = saved_sum[32] ? '1 : saved_sum[31:0];
                    state_next      = S_DONE;
                end else begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_CMP_RD;
                end
            end
            S_CP_RD: begin
                if (cnt_reg == len_reg) begin
                    // terminating zero and slot commit together
                    store_we        = 1'b1;
                    store_wdata     = '0;
                    slot_we         = 1'b1;
                    res_status_next = sih_pkg::ST_INSERTED;
                    res_handle_next = idx_reg;
                    res_off_next    = used_reg[AW-1:0];
                    used_next       = UW'(fit_sum);
                    entries_next    = entries_reg + 1'b1;
                    state_next      = S_DONE;
                end else begin
                    state_next = S_CP_WR;
                end
            end
            S_CP_WR: begin
                store_we   = 1'b1;
                cnt_next   = cnt_reg + 1'b1;
                state_next = S_CP_RD;
            end
            S_DONE: begin
                if (!m_valid_reg) begin
                    m_valid_next   = 1'b1;
                    m_status_next  = res_status_reg;
                    m_handle_next  = 12'(res_handle_reg);
                    m_off_next     = 16'(res_off_reg);
                    m_hash_next    = hash_reg;
                    m_entries_next = entries_reg;
                    m_saved_next   = saved_reg;
                    hash_next      = sih_pkg::FNV_BASIS;
                    len_next       = '0;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            hash_reg    <= sih_pkg::FNV_BASIS;
            len_reg     <= '0;
            used_reg    <= '0;
            entries_reg <= '0;
            saved_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            hash_reg    <= hash_next;
            len_reg     <= len_next;
            used_reg    <= used_next;
            entries_reg <= entries_next;
            saved_reg   <= saved_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        probes_reg     <= probes_next;
        cnt_reg        <= cnt_next;
        off_reg        <= off_next;
        res_status_reg <= res_status_next;
        res_handle_reg <= res_handle_next;
        res_off_reg    <= res_off_next;
        m_status_reg   <= m_status_next;
        m_handle_reg   <= m_handle_next;
        m_off_reg      <= m_off_next;
        m_hash_reg     <= m_hash_next;
        m_entries_reg  <= m_entries_next;
        m_saved_reg    <= m_saved_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_slot_handle  = m_handle_reg;
    assign m_store_offset = m_off_reg;
    assign m_string_hash  = m_hash_reg;
    assign m_entries_held = m_entries_reg;
    assign m_bytes_saved  = m_saved_reg;

endmodule
